@@ hdl/cbag_pkg.sv @@
`default_nettype none

package cbag_pkg;

    // opcode carried in the input tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // result kind carried in the output tuser
    typedef enum logic [1:0] {
        KIND_WINDOW = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_IDLE   = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLUMN_OFFSET = 2'd2;
    localparam logic [1:0] REG_ROW_OFFSET    = 2'd3;

    localparam logic [7:0] SCREEN_WIDTH_RST  = 8'd160;
    localparam logic [7:0] SCREEN_HEIGHT_RST = 8'd128;

    localparam int SIZE_BITS  = 11;
    localparam int INDEX_BITS = 22;
    localparam int BYTE_BITS  = 8;

    // output tdata: four window bytes then the pixel index, padded to bytes
    localparam int OUT_BITS  = 4 * BYTE_BITS + INDEX_BITS;
    localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ hdl/clipped_blit_address_generator_top.sv @@
`default_nettype none

// Channel   Dir  Handshake                  Payload
// --------  ---  -------------------------  ------------------------------------------
// s_axis    in   s_axis_tvalid/tready       tdata: pos_x, pos_y, bmp_width, bmp_height
//                                           tuser: opcode
// m_axis    out  m_axis_tvalid/tready       tdata: col_start, col_end, row_start,
//                                           row_end, pixel_index; tuser: kind; tlast: last
// cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data (always ready)
//
// One result beat per input beat, one beat per cycle sustained while the output is ready.
// A beat lands in the input register, is clipped or stepped combinationally and lands
// in the output register. The start path is one compare/clip layer plus one small
// multiply (top skip times width) ahead of the output register. A stalled output holds
// both registers; the input takes a beat whenever its register is empty or moving.
// Reset (sync, active low) clears valids and blit state and restores config defaults.

module clipped_blit_address_generator_top #(
    parameter int COORD_BITS = 12
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,

    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [COORD_BITS-1:0] pos_x, then pos_y, bmp_width (11), bmp_height (11), zero pad
    input  wire  [((2 * COORD_BITS + 2 * cbag_pkg::SIZE_BITS + 7) / 8) * 8 - 1:0]
                                               s_axis_tdata,
    // [0] opcode
    input  wire                                s_axis_tuser,

    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [7:0] col_start, [15:8] col_end, [23:16] row_start, [31:24] row_end,
    // [53:32] pixel_index, zero pad
    output logic [cbag_pkg::OUT_TDATA-1:0]     m_axis_tdata,
    // [1:0] kind
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,

    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [1:0]                         i_cfg_index,
    input  wire  [7:0]                         i_cfg_data
);

    localparam int SB       = cbag_pkg::SIZE_BITS;
    localparam int IB       = cbag_pkg::INDEX_BITS;
    localparam int IN_BITS  = 2 * COORD_BITS + 2 * SB;
    // signed working width for position plus size arithmetic
    localparam int EW       = COORD_BITS + 12;
    localparam int PW       = COORD_BITS + SB;
    localparam int MW       = (PW > IB) ? PW : IB;

    // configuration
    logic [7:0] r_scr_w, r_scr_h, r_col_off, r_row_off;

    // input stage
    logic                  r_in_vld;
    logic                  r_in_op;
    logic [IN_BITS-1:0]    r_in_data;

    // blit state
    logic                  r_active;
    logic [IB-1:0]         r_src_idx;
    logic [7:0]            r_col_cnt, r_row_cnt, r_vis_cols, r_vis_rows;
    logic [SB-1:0]         r_left_skip, r_right_skip;

    logic                  n_active;
    logic [IB-1:0]         n_src_idx;
    logic [7:0]            n_col_cnt, n_row_cnt, n_vis_cols, n_vis_rows;
    logic [SB-1:0]         n_left_skip, n_right_skip;

    // output stage
    logic                  r_out_vld;
    cbag_pkg::t_kind       r_kind, n_kind;
    logic [7:0]            r_cs, r_ce, r_rs, r_re, n_cs, n_ce, n_rs, n_re;
    logic [IB-1:0]         r_pix, n_pix;
    logic                  r_last, n_last;

    logic                  adv;
    logic                  fire;

    // start-path arithmetic
    logic [COORD_BITS-1:0] f_x, f_y;
    logic [SB-1:0]         f_w, f_h;
    logic signed [EW-1:0]  x_s, y_s, w_s, h_s, sw_s, sh_s;
    logic signed [EW-1:0]  xmax_s, ymax_s, dx2_s, negx_s, negy_s;
    logic [7:0]            cxmin, cxmax, cymin, cymax;
    logic                  off_screen, thin;
    logic [COORD_BITS-1:0] dx1, dy1;
    logic [MW-1:0]         prod;

    // next-path
    logic                  col_wrap, row_wrap;

    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || adv;
    assign fire          = r_in_vld && adv;
    assign o_cfg_ready   = 1'b1;

    assign f_x = r_in_data[COORD_BITS-1:0];
    assign f_y = r_in_data[2*COORD_BITS-1:COORD_BITS];
    assign f_w = r_in_data[2*COORD_BITS+SB-1:2*COORD_BITS];
    assign f_h = r_in_data[2*COORD_BITS+2*SB-1:2*COORD_BITS+SB];

    always_comb begin
        x_s    = EW'(signed'(f_x));
        y_s    = EW'(signed'(f_y));
        w_s    = signed'({{(EW-SB){1'b0}}, f_w});
        h_s    = signed'({{(EW-SB){1'b0}}, f_h});
        sw_s   = signed'({{(EW-8){1'b0}}, r_scr_w});
        sh_s   = signed'({{(EW-8){1'b0}}, r_scr_h});
        xmax_s = x_s + w_s - EW'(1);
        ymax_s = y_s + h_s - EW'(1);
        dx2_s  = x_s + w_s - sw_s;
        negx_s = -x_s;
        negy_s = -y_s;

        off_screen = (f_w == '0) || (f_h == '0) || (r_scr_w == '0) || (r_scr_h == '0)
                  || (x_s >= sw_s) || (xmax_s < 0) || (y_s >= sh_s) || (ymax_s < 0);

        // clipped bounds; only meaningful when on screen, then all fit in a byte
        cxmin = (x_s < 0) ? 8'd0 : x_s[7:0];
        cxmax = (xmax_s >= sw_s) ? (r_scr_w - 8'd1) : xmax_s[7:0];
        cymin = (y_s < 0) ? 8'd0 : y_s[7:0];
        cymax = (ymax_s >= sh_s) ? (r_scr_h - 8'd1) : ymax_s[7:0];
        // single-column or single-row windows are rejected too
        thin  = (cxmin == cxmax) || (cymin == cymax);

        dx1  = (x_s < 0) ? negx_s[COORD_BITS-1:0] : '0;
        dy1  = (y_s < 0) ? negy_s[COORD_BITS-1:0] : '0;
        prod = MW'(dy1) * MW'(f_w);

        col_wrap = ({1'b0, r_col_cnt} + 9'd1) >= {1'b0, r_vis_cols};
        row_wrap = ({1'b0, r_row_cnt} + 9'd1) >= {1'b0, r_vis_rows};

        n_active     = r_active;
        n_src_idx    = r_src_idx;
        n_col_cnt    = r_col_cnt;
        n_row_cnt    = r_row_cnt;
        n_vis_cols   = r_vis_cols;
        n_vis_rows   = r_vis_rows;
        n_left_skip  = r_left_skip;
        n_right_skip = r_right_skip;

        n_kind = cbag_pkg::KIND_IDLE;
        n_cs   = '0;
        n_ce   = '0;
        n_rs   = '0;
        n_re   = '0;
        n_pix  = '0;
        n_last = 1'b0;

        if (r_in_op == cbag_pkg::OP_START) begin
            n_active = 1'b0;
            if (off_screen || thin) begin
                n_kind = cbag_pkg::KIND_REJECT;
            end else begin
                n_kind       = cbag_pkg::KIND_WINDOW;
                n_active     = 1'b1;
                n_left_skip  = SB'(dx1);
                n_right_skip = (dx2_s > 0) ? dx2_s[SB-1:0] : '0;
                n_vis_cols   = cxmax - cxmin + 8'd1;
                n_vis_rows   = cymax - cymin + 8'd1;
                n_col_cnt    = '0;
                n_row_cnt    = '0;
                n_src_idx    = prod[IB-1:0] + IB'(dx1);
                n_cs         = cxmin + r_col_off;
                n_ce         = cxmax + r_col_off;
                n_rs         = cymin + r_row_off;
                n_re         = cymax + r_row_off;
            end
        end else if (r_active) begin
            n_kind = cbag_pkg::KIND_PIXEL;
            n_pix  = r_src_idx;
            if (col_wrap) begin
                n_col_cnt = '0;
                if (row_wrap) begin
                    n_last    = 1'b1;
                    n_active  = 1'b0;
                    n_row_cnt = '0;
                end else begin
                    n_row_cnt = r_row_cnt + 8'd1;
                end
                // jump over the clipped right edge of this row and left edge of the next
                n_src_idx = r_src_idx + IB'(1) + IB'(r_right_skip) + IB'(r_left_skip);
            end else begin
                n_col_cnt = r_col_cnt + 8'd1;
                n_src_idx = r_src_idx + IB'(1);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w   <= cbag_pkg::SCREEN_WIDTH_RST;
            r_scr_h   <= cbag_pkg::SCREEN_HEIGHT_RST;
            r_col_off <= '0;
            r_row_off <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cbag_pkg::REG_SCREEN_WIDTH:  r_scr_w   <= i_cfg_data;
                cbag_pkg::REG_SCREEN_HEIGHT: r_scr_h   <= i_cfg_data;
                cbag_pkg::REG_COLUMN_OFFSET: r_col_off <= i_cfg_data;
                cbag_pkg::REG_ROW_OFFSET:    r_row_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_data <= s_axis_tdata[IN_BITS-1:0];
        end
    end

    // blit state, updated as a beat moves into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_src_idx    <= '0;
            r_col_cnt    <= '0;
            r_row_cnt    <= '0;
            r_vis_cols   <= '0;
            r_vis_rows   <= '0;
            r_left_skip  <= '0;
            r_right_skip <= '0;
        end else if (fire) begin
            r_active     <= n_active;
            r_src_idx    <= n_src_idx;
            r_col_cnt    <= n_col_cnt;
            r_row_cnt    <= n_row_cnt;
            r_vis_cols   <= n_vis_cols;
            r_vis_rows   <= n_vis_rows;
            r_left_skip  <= n_left_skip;
            r_right_skip <= n_right_skip;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kind <= n_kind;
            r_cs   <= n_cs;
            r_ce   <= n_ce;
            r_rs   <= n_rs;
            r_re   <= n_re;
            r_pix  <= n_pix;
            r_last <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = cbag_pkg::OUT_TDATA'({r_pix, r_re, r_rs, r_ce, r_cs});

endmodule

`default_nettype wire

@@ sim/clipped_blit_address_generator_top_tb.sv @@
`timescale 1ns / 1ps

module clipped_blit_address_generator_top_tb;

    localparam int COORD_BITS  = 12;
    localparam int SIZE_BITS   = cbag_pkg::SIZE_BITS;
    localparam int INDEX_BITS  = cbag_pkg::INDEX_BITS;
    // pos_x, pos_y, bmp_width, bmp_height packed from bit 0, padded to bytes
    localparam int IN_TDATA    = ((2 * COORD_BITS + 2 * SIZE_BITS + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        cbag_pkg::t_kind        kind;
        logic [7:0]             col_start;
        logic [7:0]             col_end;
        logic [7:0]             row_start;
        logic [7:0]             row_end;
        logic [INDEX_BITS-1:0]  pixel_index;
        logic                   last;
    } t_blit_result;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA-1:0]    s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [cbag_pkg::OUT_TDATA-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index   = '0;
    logic [7:0]             i_cfg_data    = '0;

    // Shadow of the block: configuration and blit walk state, all at reset values.
    logic [7:0]             scr_width  = cbag_pkg::SCREEN_WIDTH_RST;
    logic [7:0]             scr_height = cbag_pkg::SCREEN_HEIGHT_RST;
    logic [7:0]             col_offset = '0;
    logic [7:0]             row_offset = '0;
    logic                   blit_active = 1'b0;
    logic [INDEX_BITS-1:0]  src_index  = '0;
    logic [SIZE_BITS-1:0]   col_count  = '0;
    logic [SIZE_BITS-1:0]   row_count  = '0;
    logic [SIZE_BITS-1:0]   vis_cols   = '0;
    logic [SIZE_BITS-1:0]   vis_rows   = '0;
    logic [SIZE_BITS-1:0]   skip_left  = '0;
    logic [SIZE_BITS-1:0]   skip_right = '0;

    t_blit_result           pending_results[$];
    t_blit_result           head_result;
    int                     errors       = 0;
    int                     beats_sent   = 0;
    int                     quiet_cycles = 0;
    int                     stall_left   = 0;
    bit                     idling_on    = 1'b1;

    clipped_blit_address_generator_top #(
        .COORD_BITS (COORD_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly no gap, some short ones, a few long ones; none while idling is off.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Clip/walk predictor: returns the result beat for one input beat and
    // advances the shadow state.
    function automatic t_blit_result next_blit_result(input logic op,
            input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
            input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
        t_blit_result r;
        int x, y, wi, hi, sw, sh, xmin, xmax, ymin, ymax, dx1, dx2, dy1, sum, cc, rc;
        r = '0;
        if (op == cbag_pkg::OP_START) begin
            x  = $signed(px);
            y  = $signed(py);
            wi = w;
            hi = h;
            sw = scr_width;
            sh = scr_height;
            xmin = x;
            xmax = x + wi - 1;
            ymin = y;
            ymax = y + hi - 1;
            // any start drops a running blit
            blit_active = 1'b0;
            if (wi == 0 || hi == 0 || sw == 0 || sh == 0 ||
                    xmin >= sw || xmax < 0 || ymin >= sh || ymax < 0) begin
                r.kind = cbag_pkg::KIND_REJECT;
                return r;
            end
            if (xmax >= sw) xmax = sw - 1;
            if (xmin < 0) xmin = 0;
            if (ymax >= sh) ymax = sh - 1;
            if (ymin < 0) ymin = 0;
            // one column or one row wide windows are refused too
            if (xmin == xmax || ymin == ymax) begin
                r.kind = cbag_pkg::KIND_REJECT;
                return r;
            end
            dx1 = (x < 0) ? -x : 0;
            dx2 = x + wi - sw;
            if (dx2 < 0) dx2 = 0;
            dy1 = (y < 0) ? -y : 0;
            skip_left  = dx1[SIZE_BITS-1:0];
            skip_right = dx2[SIZE_BITS-1:0];
            vis_cols   = SIZE_BITS'(xmax - xmin + 1);
            vis_rows   = SIZE_BITS'(ymax - ymin + 1);
            col_count  = '0;
            row_count  = '0;
            sum        = dy1 * wi + dx1;
            src_index  = sum[INDEX_BITS-1:0];
            blit_active = 1'b1;
            r.kind      = cbag_pkg::KIND_WINDOW;
            r.col_start = 8'(xmin + col_offset);
            r.col_end   = 8'(xmax + col_offset);
            r.row_start = 8'(ymin + row_offset);
            r.row_end   = 8'(ymax + row_offset);
        end else if (!blit_active) begin
            r.kind = cbag_pkg::KIND_IDLE;
        end else begin
            r.kind        = cbag_pkg::KIND_PIXEL;
            r.pixel_index = src_index;
            cc = col_count;
            rc = row_count;
            if (cc + 1 >= int'(vis_cols)) begin
                col_count = '0;
                if (rc + 1 >= int'(vis_rows)) begin
                    r.last      = 1'b1;
                    blit_active = 1'b0;
                    row_count   = '0;
                end else begin
                    row_count = SIZE_BITS'(rc + 1);
                end
                // hop over the clipped right part of this row and left part of the next
                src_index = INDEX_BITS'(src_index + 1 + skip_right + skip_left);
            end else begin
                col_count = SIZE_BITS'(cc + 1);
                src_index = src_index + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic int pixels_left();
        if (!blit_active) return 0;
        return (int'(vis_rows) - int'(row_count)) * int'(vis_cols) - int'(col_count);
    endfunction

    // Position near an edge half the time so clipping is exercised.
    function automatic int place_coord(input int extent, input int length);
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, extent + 4)) - 4;
            1: return extent - int'($urandom_range(1, 6));
            2: return int'($urandom_range(1, 6)) - length;
            default: return int'($urandom_range(0, 4095)) - 2048;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // One input beat. A valid that stays high into the next beat is never
    // dropped and raised within the same step.
    task automatic send_beat(input logic op, input logic [COORD_BITS-1:0] px,
            input logic [COORD_BITS-1:0] py, input logic [SIZE_BITS-1:0] w,
            input logic [SIZE_BITS-1:0] h);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA'({h, w, py, px});
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(next_blit_result(op, px, py, w, h));
        beats_sent++;
    endtask

    // Geometry fields are don't-care on a next beat; fill them with noise.
    task automatic send_next();
        send_beat(cbag_pkg::OP_NEXT, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Start a blit, walk up to max_px pixels, then poke it after completion.
    task automatic run_blit(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
            input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h,
            input int max_px, input int extra);
        int n;
        send_beat(cbag_pkg::OP_START, px, py, w, h);
        n = pixels_left();
        if (n > max_px) n = max_px;
        repeat (n) send_next();
        if (!blit_active) repeat (extra) send_next();
    endtask

    // Sender holds off until every pending result beat has come back.
    task automatic settle_blits();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            cbag_pkg::REG_SCREEN_WIDTH:  scr_width  = val;
            cbag_pkg::REG_SCREEN_HEIGHT: scr_height = val;
            cbag_pkg::REG_COLUMN_OFFSET: col_offset = val;
            cbag_pkg::REG_ROW_OFFSET:    row_offset = val;
        endcase
    endtask

    // Registers only change with the block drained.
    task automatic write_config(input logic [7:0] sw, input logic [7:0] sh,
            input logic [7:0] co, input logic [7:0] ro);
        settle_blits();
        write_reg(cbag_pkg::REG_SCREEN_WIDTH, sw);
        write_reg(cbag_pkg::REG_SCREEN_HEIGHT, sh);
        write_reg(cbag_pkg::REG_COLUMN_OFFSET, co);
        write_reg(cbag_pkg::REG_ROW_OFFSET, ro);
        i_cfg_valid <= 1'b0;
    endtask

    // Reset screen: idle next, every geometry reject reason, clipped walks on all sides,
    // restart while a blit runs.
    task automatic test_idle_and_rejects();
        send_next();                                             // nothing active yet
        send_beat(cbag_pkg::OP_START, -2048, -2048, 1, 1);       // fully above-left
        send_beat(cbag_pkg::OP_START, 2047, 2047, 2047, 2047);   // fully below-right
        send_beat(cbag_pkg::OP_START, 10, 10, 0, 5);             // zero width
        send_beat(cbag_pkg::OP_START, 10, 10, 5, 0);             // zero height
        send_beat(cbag_pkg::OP_START, -5, 3, 6, 4);              // clips to one column
        send_beat(cbag_pkg::OP_START, 3, -5, 4, 6);              // clips to one row
        run_blit(-3, -2, 6, 5, 20, 1);                           // left/top clip, then idle
        run_blit(158, 126, 2047, 2047, 20, 1);                   // right/bottom clip
        run_blit(0, 0, 2047, 2047, 3, 0);                        // left running...
        run_blit(100, 50, 3, 2, 2, 0);                           // ...and restarted
        send_beat(cbag_pkg::OP_START, 5, 5, 0, 3);               // rejected restart
        send_next();                                             // block is idle again
    endtask

    // Register extremes: full offsets wrap the window bytes, empty or
    // single-column screens refuse everything.
    task automatic test_window_extremes();
        write_config(8'd255, 8'd255, 8'd255, 8'd255);
        run_blit(250, 250, 10, 10, 8, 0);
        write_config(8'd0, 8'd255, 8'd0, 8'd0);
        send_beat(cbag_pkg::OP_START, 0, 0, 4, 4);
        write_config(8'd1, 8'd255, 8'd0, 8'd0);
        send_beat(cbag_pkg::OP_START, 0, 0, 4, 4);
        write_config(8'd255, 8'd0, 8'd0, 8'd0);
        send_beat(cbag_pkg::OP_START, 0, 0, 4, 4);
        send_next();
    endtask

    // Mostly whole or cut-short blits with random geometry, the rest noise.
    task automatic test_random_blits(input int count, input bit idle);
        int stop, x, y;
        logic [SIZE_BITS-1:0] w, h;
        idling_on = idle;
        stop = beats_sent + count;
        while (beats_sent < stop) begin
            if ($urandom_range(0, 3) == 0) begin
                send_beat($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
            end else begin
                w = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : $urandom_range(1, 2047);
                h = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : $urandom_range(1, 2047);
                x = place_coord(scr_width, w);
                y = place_coord(scr_height, h);
                run_blit(x, y, w, h,
                         ($urandom_range(0, 6) == 0) ? $urandom_range(0, 5) : 60,
                         $urandom_range(0, 2));
            end
        end
        idling_on = 1'b1;
    endtask

    // Output side: random stall bursts, none while idling is off.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
        end
    end

    // Result checker: every result beat against the oldest pending prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with none pending, expected nothing, actual kind %0d",
                         $time, m_axis_tuser);
            end else begin
                head_result = pending_results.pop_front();
                check_field("kind", head_result.kind, m_axis_tuser);
                check_field("col_start", head_result.col_start, m_axis_tdata[7:0]);
                check_field("col_end", head_result.col_end, m_axis_tdata[15:8]);
                check_field("row_start", head_result.row_start, m_axis_tdata[23:16]);
                check_field("row_end", head_result.row_end, m_axis_tdata[31:24]);
                check_field("pixel_index", head_result.pixel_index, m_axis_tdata[53:32]);
                check_field("last", head_result.last, m_axis_tlast);
            end
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_rejects();
        test_window_extremes();

        write_config(cbag_pkg::SCREEN_WIDTH_RST, cbag_pkg::SCREEN_HEIGHT_RST,
                     $urandom, $urandom);
        test_random_blits(100, 1'b1);
        // tiny screen, back to back with no gaps or stalls
        write_config($urandom_range(2, 12), $urandom_range(2, 12), 8'd0, 8'd0);
        test_random_blits(100, 1'b0);
        write_config(8'd255, 8'd255, 8'd255, 8'd255);
        test_random_blits(80, 1'b1);
        repeat (3) begin
            write_config($urandom_range(0, 1) ? $urandom_range(1, 255) : $urandom_range(2, 16),
                         $urandom_range(0, 1) ? $urandom_range(1, 255) : $urandom_range(2, 16),
                         $urandom, $urandom);
            test_random_blits(70, 1'b1);
        end

        settle_blits();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
